// ===== rtl/pdt_pkg.sv =====
// package for the packet delivery tracker
// holds event and phase codes, the slot record type and small helpers; no dependencies
package pdt_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam logic [31:0] TtlReset = 32'd30000;

  // event codes
  localparam logic [3:0] FN_BEGIN      = 4'd0;
  localparam logic [3:0] FN_PRIM_ACT   = 4'd1;
  localparam logic [3:0] FN_PRIM_FAIL  = 4'd2;
  localparam logic [3:0] FN_QUEUE_REC  = 4'd3;
  localparam logic [3:0] FN_QUERY_SEC  = 4'd4;
  localparam logic [3:0] FN_START_SEC  = 4'd5;
  localparam logic [3:0] FN_CARRIER    = 4'd6;
  localparam logic [3:0] FN_DELIVERED  = 4'd7;
  localparam logic [3:0] FN_CANCELLED  = 4'd8;
  localparam logic [3:0] FN_EXPIRE     = 4'd9;
  localparam logic [3:0] FN_CLEAR      = 4'd10;

  // phase codes
  localparam logic [2:0] PH_PRIM  = 3'd0;
  localparam logic [2:0] PH_RECOV = 3'd1;
  localparam logic [2:0] PH_SEC   = 3'd2;
  localparam logic [2:0] PH_ACC   = 3'd3;
  localparam logic [2:0] PH_DELIV = 3'd4;
  localparam logic [2:0] PH_CANC  = 3'd5;
  localparam logic [2:0] PH_EXP   = 3'd6;

  // path codes
  localparam logic [1:0] PATH_NONE    = 2'd0;
  localparam logic [1:0] PATH_PRIMARY = 2'd1;
  localparam logic [1:0] PATH_SECOND  = 2'd2;
  localparam logic [1:0] PATH_THIRD   = 2'd3;

  localparam logic [7:0] CountMax = 8'hFF;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] pkt;
    logic [2:0]  phase;
    logic [1:0]  path;
    logic [2:0]  tried;
    logic [2:0]  acc;
    logic [7:0]  fails;
    logic [7:0]  secs;
    logic [31:0] created;
    logic [31:0] updated;
  } rec_t;

  // outcome of one event on the looked-up record
  typedef struct packed {
    logic ok;
    logic wr;
    logic found;
    rec_t rec;
  } exec_res_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EXEC} state_e;

  function automatic logic is_term(logic [2:0] ph);
    return ph >= PH_DELIV;
  endfunction

  function automatic logic [2:0] path_bit(logic [1:0] p);
    logic [2:0] b;
    unique case (p)
      PATH_PRIMARY: b = 3'b001;
      PATH_SECOND:  b = 3'b010;
      PATH_THIRD:   b = 3'b100;
      default:      b = 3'b000;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] sat_inc(logic [7:0] v);
    return (v == CountMax) ? v : v + 8'd1;
  endfunction

endpackage

// ===== rtl/pdt_mem.sv =====
// slot record memory, one write port and one registered read port
// depends on pdt_pkg for the record type
module pdt_mem import pdt_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDefault,
  parameter int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk_i,
  input  logic [IW-1:0] rd_addr_i,
  output rec_t          rd_data_o,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  rec_t          wr_data_i
);

  rec_t mem_q [SLOTS];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ===== rtl/pdt_exec.sv =====
// event update: applies one event to the looked-up record
// depends on pdt_pkg for codes, record type and helpers
module pdt_exec import pdt_pkg::*; (
  input  logic [3:0]  func_i,
  input  logic [31:0] dest_i,
  input  logic [31:0] pkt_i,
  input  logic [1:0]  path_i,
  input  logic        acc_i,
  input  logic [31:0] now_i,
  input  logic        found_i,
  input  rec_t        rec_i,
  output exec_res_t   res_o
);

  function automatic logic may_start(logic [1:0] p, logic fnd, rec_t r);
    logic m;
    if (p != PATH_SECOND && p != PATH_THIRD) m = 1'b0;
    else if (!fnd) m = 1'b1;
    else if (is_term(r.phase)) m = 1'b0;
    else if (r.phase == PH_SEC && r.path != p) m = 1'b0;
    else if (r.phase == PH_ACC) m = 1'b0;
    else m = 1'b1;
    return m;
  endfunction

  logic zero_key;
  logic begin_ok;
  rec_t brec;

  // begin step shared by several events
  always_comb begin
    zero_key = (dest_i == '0) || (pkt_i == '0);
    brec     = rec_i;
    begin_ok = 1'b0;
    if (zero_key) begin
      begin_ok = 1'b0;
    end else if (found_i) begin
      begin_ok     = !is_term(rec_i.phase);
      brec.updated = now_i;
    end else begin
      begin_ok     = 1'b1;
      brec.dest    = dest_i;
      brec.pkt     = pkt_i;
      brec.phase   = PH_PRIM;
      brec.path    = PATH_PRIMARY;
      brec.tried   = path_bit(PATH_PRIMARY);
      brec.acc     = '0;
      brec.fails   = '0;
      brec.secs    = '0;
      brec.created = now_i;
      brec.updated = now_i;
    end
  end

  // per-event update
  always_comb begin
    res_o.ok  = 1'b0;
    res_o.wr  = 1'b0;
    res_o.rec = rec_i;
    unique case (func_i)
      FN_BEGIN: begin
        res_o.ok  = begin_ok;
        res_o.wr  = begin_ok;
        res_o.rec = brec;
      end
      FN_PRIM_ACT: begin
        res_o.ok  = begin_ok;
        res_o.wr  = begin_ok;
        res_o.rec = brec;
        if (begin_ok) begin
          res_o.rec.phase = PH_PRIM;
          res_o.rec.path  = PATH_PRIMARY;
          res_o.rec.tried = brec.tried | path_bit(PATH_PRIMARY);
        end
      end
      FN_PRIM_FAIL: begin
        res_o.ok  = begin_ok;
        res_o.wr  = begin_ok;
        res_o.rec = brec;
        if (brec.phase == PH_PRIM) begin
          res_o.rec.fails = sat_inc(brec.fails);
          res_o.rec.phase = PH_RECOV;
          res_o.rec.path  = PATH_NONE;
        end
      end
      FN_QUEUE_REC: begin
        res_o.ok  = begin_ok;
        res_o.wr  = begin_ok;
        res_o.rec = brec;
        if (begin_ok) begin
          res_o.rec.phase = PH_RECOV;
          res_o.rec.path  = PATH_NONE;
        end
      end
      FN_QUERY_SEC: begin
        res_o.ok = may_start(path_i, found_i, rec_i);
      end
      FN_START_SEC: begin
        res_o.wr  = begin_ok;
        res_o.rec = brec;
        if (begin_ok && may_start(path_i, 1'b1, brec)) begin
          res_o.ok = 1'b1;
          res_o.rec.phase = PH_SEC;
          res_o.rec.path  = path_i;
          res_o.rec.tried = brec.tried | path_bit(path_i);
          res_o.rec.secs  = sat_inc(brec.secs);
        end
      end
      FN_CARRIER: begin
        if (found_i && !is_term(rec_i.phase) &&
            !(rec_i.phase == PH_SEC && rec_i.path != path_i)) begin
          res_o.ok = 1'b1;
          res_o.wr = 1'b1;
          res_o.rec.updated = now_i;
          res_o.rec.path    = PATH_NONE;
          if (acc_i) begin
            res_o.rec.acc   = rec_i.acc | path_bit(path_i);
            res_o.rec.phase = PH_ACC;
          end else begin
            res_o.rec.phase = PH_RECOV;
          end
        end
      end
      FN_DELIVERED: begin
        if (found_i && rec_i.phase != PH_CANC && rec_i.phase != PH_EXP) begin
          res_o.ok = 1'b1;
          res_o.wr = 1'b1;
          res_o.rec.phase   = PH_DELIV;
          res_o.rec.path    = PATH_NONE;
          res_o.rec.updated = now_i;
        end
      end
      FN_CANCELLED: begin
        if (found_i && rec_i.phase != PH_DELIV && rec_i.phase != PH_EXP) begin
          res_o.ok = 1'b1;
          res_o.wr = 1'b1;
          res_o.rec.phase   = PH_CANC;
          res_o.rec.path    = PATH_NONE;
          res_o.rec.updated = now_i;
        end
      end
      FN_EXPIRE, FN_CLEAR: begin
        res_o.ok = 1'b1;
      end
      default: begin
        res_o.ok = 1'b0;
      end
    endcase
    res_o.found = found_i || res_o.wr;
  end

endmodule

// ===== rtl/packet_delivery_tracker_unit.sv =====
// packet delivery tracker, top level: scan sequencer, slot valid bits, result register
// depends on pdt_pkg, pdt_mem and pdt_exec
//
// channel   | signals                                         | handshake
// request   | func_i destination_i packet_id_i carrier_path_i | start_i while busy_o low
//           | carrier_accepted_i now_ms_i                     |
// result    | ok_o found_o phase_o active_path_o tried_mask_o | valid_o strobe, one cycle
//           | accepted_mask_o fail_count_o secondary_count_o  |
// config    | cfg_wdata_i (ttl_ms)                            | cfg_we_i
//
// an event holds busy_o through the scan, with one memory read per slot, and then through
// the exec state that updates and writes back the record; clear skips the scan and holds busy_o for the exec state only
// the result strobe is high in the first cycle with busy_o low, registered from the exec state;
// the receiver cannot stall
// reset empties the table at once through the slot valid bits and loads ttl 30000
module packet_delivery_tracker_unit import pdt_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  func_i,
  input  logic [31:0] destination_i,
  input  logic [31:0] packet_id_i,
  input  logic [1:0]  carrier_path_i,
  input  logic        carrier_accepted_i,
  input  logic [31:0] now_ms_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        valid_o,
  output logic        ok_o,
  output logic        found_o,
  output logic [2:0]  phase_o,
  output logic [1:0]  active_path_o,
  output logic [2:0]  tried_mask_o,
  output logic [2:0]  accepted_mask_o,
  output logic [7:0]  fail_count_o,
  output logic [7:0]  secondary_count_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

  state_e state_q, state_d;
  logic [IW-1:0] cnt_q;
  logic [SLOTS-1:0] used_q;
  logic [31:0] ttl_q;

  // latched request
  logic [3:0]  func_q;
  logic [31:0] dest_q, pkt_q, now_q;
  logic [1:0]  path_q;
  logic        acc_q;

  // scan results
  logic found_q, free_found_q, term_found_q;
  logic [IW-1:0] match_idx_q, free_idx_q, term_idx_q, old_idx_q;
  logic [31:0] old_age_q;
  rec_t rec_q;

  logic accept;
  logic [IW-1:0] rd_addr, wr_addr, target;
  rec_t rd_rec, wr_rec, exp_rec, scan_rec;
  logic wr_en;
  logic slot_used, slot_hit, expire_hit;
  logic [31:0] age;
  exec_res_t res;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);

  pdt_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_rec),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_rec)
  );

  pdt_exec u_exec (
    .func_i  (func_q),
    .dest_i  (dest_q),
    .pkt_i   (pkt_q),
    .path_i  (path_q),
    .acc_i   (acc_q),
    .now_i   (now_q),
    .found_i (found_q),
    .rec_i   (rec_q),
    .res_o   (res)
  );

  // scan datapath on the slot just read
  always_comb begin
    rd_addr    = (state_q == ST_IDLE) ? '0 : cnt_q + 1'b1;
    slot_used  = used_q[cnt_q];
    slot_hit   = slot_used && (rd_rec.dest == dest_q) && (rd_rec.pkt == pkt_q);
    age        = now_q - rd_rec.updated;
    expire_hit = (state_q == ST_SCAN) && (func_q == FN_EXPIRE) && slot_used &&
                 !is_term(rd_rec.phase) && ((now_q - rd_rec.created) > ttl_q);
    exp_rec         = rd_rec;
    exp_rec.phase   = PH_EXP;
    exp_rec.path    = PATH_NONE;
    exp_rec.updated = now_q;
    scan_rec = expire_hit ? exp_rec : rd_rec;
  end

  // slot for the record: the match, else a free slot, else terminal, else oldest
  always_comb begin
    priority if (found_q)      target = match_idx_q;
    else if (free_found_q)     target = free_idx_q;
    else if (term_found_q)     target = term_idx_q;
    else                       target = old_idx_q;
  end

  // memory write port: expiry during the scan, update at the end
  always_comb begin
    wr_en   = expire_hit;
    wr_addr = cnt_q;
    wr_rec  = exp_rec;
    if (state_q == ST_EXEC) begin
      wr_en   = res.wr && (func_q != FN_CLEAR);
      wr_addr = target;
      wr_rec  = res.rec;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = (func_i == FN_CLEAR) ? ST_EXEC : ST_SCAN;
      ST_SCAN: if (cnt_q == LastIdx) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      used_q       <= '0;
      ttl_q        <= TtlReset;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      term_found_q <= 1'b0;
      valid_o      <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_o <= (state_q == ST_EXEC);
      if (cfg_we_i) ttl_q <= cfg_wdata_i;
      if (accept) begin
        cnt_q        <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
        term_found_q <= 1'b0;
      end
      if (state_q == ST_SCAN) begin
        cnt_q <= cnt_q + 1'b1;
        if (slot_hit && !found_q) found_q <= 1'b1;
        if (!slot_used && !free_found_q) free_found_q <= 1'b1;
        if (slot_used && is_term(rd_rec.phase) && !term_found_q) term_found_q <= 1'b1;
      end
      if (state_q == ST_EXEC) begin
        if (func_q == FN_CLEAR) used_q <= '0;
        else if (res.wr) used_q[target] <= 1'b1;
      end
    end
  end

  // request and scan payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      dest_q <= destination_i;
      pkt_q  <= packet_id_i;
      path_q <= carrier_path_i;
      acc_q  <= carrier_accepted_i;
      now_q  <= now_ms_i;
    end
    if (state_q == ST_SCAN) begin
      if (slot_hit && !found_q) begin
        match_idx_q <= cnt_q;
        rec_q       <= scan_rec;
      end
      if (!slot_used && !free_found_q) free_idx_q <= cnt_q;
      if (slot_used && is_term(rd_rec.phase) && !term_found_q) term_idx_q <= cnt_q;
      if ((cnt_q == '0) || (age > old_age_q)) begin
        old_age_q <= age;
        old_idx_q <= cnt_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      if (func_q == FN_CLEAR) begin
        ok_o    <= 1'b1;
        found_o <= 1'b0;
      end else begin
        ok_o    <= res.ok;
        found_o <= res.found;
      end
      if (res.found && func_q != FN_CLEAR) begin
        phase_o           <= res.rec.phase;
        active_path_o     <= res.rec.path;
        tried_mask_o      <= res.rec.tried;
        accepted_mask_o   <= res.rec.acc;
        fail_count_o      <= res.rec.fails;
        secondary_count_o <= res.rec.secs;
      end else begin
        phase_o           <= '0;
        active_path_o     <= '0;
        tried_mask_o      <= '0;
        accepted_mask_o   <= '0;
        fail_count_o      <= '0;
        secondary_count_o <= '0;
      end
    end
  end

endmodule

// ===== rtl/pdt_checker.sv =====
// port-level checks for the packet delivery tracker, bound to the top level
// depends on the top level's ports only
module pdt_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       valid_o,
  input logic       found_o,
  input logic [2:0] phase_o,
  input logic [7:0] fail_count_o,
  input logic [7:0] secondary_count_o
);

  // an accepted request makes the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("not busy after accepted request");

  // the end of busy always comes with a result strobe, in the same cycle
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> valid_o) else $error("missing result");

  // results are single-cycle strobes and never overlap work
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o ##1 !valid_o) else $error("result strobe too long");

  // a missing record reports empty fields
  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !found_o |-> phase_o == 3'd0 && fail_count_o == 8'd0 &&
    secondary_count_o == 8'd0) else $error("fields set without a record");

endmodule

bind packet_delivery_tracker_unit pdt_port_checker u_pdt_port_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .valid_o           (valid_o),
  .found_o           (found_o),
  .phase_o           (phase_o),
  .fail_count_o      (fail_count_o),
  .secondary_count_o (secondary_count_o)
);

// ===== test/pdt_checker.sv =====
// tracker checker: watches the request, config and result ports of the delivery tracker
// keeps its own slot table to compute each expected result; depends on pdt_pkg
module pdt_checker import pdt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [3:0]  func_i,
  input  logic [31:0] destination_i,
  input  logic [31:0] packet_id_i,
  input  logic [1:0]  carrier_path_i,
  input  logic        carrier_accepted_i,
  input  logic [31:0] now_ms_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        valid_o,
  input  logic        ok_o,
  input  logic        found_o,
  input  logic [2:0]  phase_o,
  input  logic [1:0]  active_path_o,
  input  logic [2:0]  tried_mask_o,
  input  logic [2:0]  accepted_mask_o,
  input  logic [7:0]  fail_count_o,
  input  logic [7:0]  secondary_count_o,
  output int          fail_cnt,
  output int          pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSlots = 16;

  typedef struct packed {
    logic       ok;
    logic       found;
    logic [2:0] phase;
    logic [1:0] path;
    logic [2:0] tried;
    logic [2:0] acc;
    logic [7:0] fails;
    logic [7:0] secs;
  } report_t;

  logic       used   [NSlots];
  rec_t       tbl    [NSlots];
  logic [31:0] ttl;
  report_t    report_q[$];

  assign pending_cnt = report_q.size();

  function automatic logic terminal(logic [2:0] ph);
    return ph >= PH_DELIV;
  endfunction

  function automatic logic [2:0] bit_of(logic [1:0] p);
    return (p == PATH_NONE) ? 3'b000 : 3'(1 << (p - 1));
  endfunction

  function automatic logic [7:0] bump(logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic int find_key(logic [31:0] d, logic [31:0] p);
    for (int i = 0; i < NSlots; i++)
      if (used[i] && tbl[i].dest == d && tbl[i].pkt == p) return i;
    return -1;
  endfunction

  // free slot, else first terminal, else least recently updated
  function automatic int alloc_slot(logic [31:0] now);
    int old;
    old = 0;
    for (int i = 0; i < NSlots; i++)
      if (!used[i]) return i;
    for (int i = 0; i < NSlots; i++) begin
      if (terminal(tbl[i].phase)) return i;
      if (32'(now - tbl[i].updated) > 32'(now - tbl[old].updated)) old = i;
    end
    return old;
  endfunction

  function automatic int open_record(logic [31:0] d, logic [31:0] p, logic [31:0] now);
    int i;
    if (d == 0 || p == 0) return -1;
    i = find_key(d, p);
    if (i >= 0) begin
      if (terminal(tbl[i].phase)) return -1;
      tbl[i].updated = now;
      return i;
    end
    i = alloc_slot(now);
    used[i] = 1'b1;
    tbl[i] = '0;
    tbl[i].dest = d;
    tbl[i].pkt = p;
    tbl[i].phase = PH_PRIM;
    tbl[i].path = PATH_PRIMARY;
    tbl[i].tried = 3'b001;
    tbl[i].created = now;
    tbl[i].updated = now;
    return i;
  endfunction

  function automatic logic secondary_allowed(logic [31:0] d, logic [31:0] p, logic [1:0] path);
    int i;
    if (path != PATH_SECOND && path != PATH_THIRD) return 1'b0;
    i = find_key(d, p);
    if (i < 0) return 1'b1;
    if (terminal(tbl[i].phase)) return 1'b0;
    if (tbl[i].phase == PH_SEC && tbl[i].path != path) return 1'b0;
    if (tbl[i].phase == PH_ACC) return 1'b0;
    return 1'b1;
  endfunction

  function automatic report_t track_event(logic [3:0] fn, logic [31:0] d, logic [31:0] p,
                                          logic [1:0] path, logic acc, logic [31:0] now);
    report_t r;
    int i;
    r = '0;
    case (fn)
      FN_BEGIN: r.ok = open_record(d, p, now) >= 0;
      FN_PRIM_ACT: begin
        i = open_record(d, p, now);
        if (i >= 0) begin
          tbl[i].phase = PH_PRIM;
          tbl[i].path = PATH_PRIMARY;
          tbl[i].tried |= 3'b001;
          r.ok = 1'b1;
        end
      end
      FN_PRIM_FAIL: begin
        i = open_record(d, p, now);
        if (i >= 0) begin
          if (tbl[i].phase == PH_PRIM) begin
            tbl[i].fails = bump(tbl[i].fails);
            tbl[i].phase = PH_RECOV;
            tbl[i].path = PATH_NONE;
          end
          r.ok = 1'b1;
        end
      end
      FN_QUEUE_REC: begin
        i = open_record(d, p, now);
        if (i >= 0) begin
          tbl[i].phase = PH_RECOV;
          tbl[i].path = PATH_NONE;
          r.ok = 1'b1;
        end
      end
      FN_QUERY_SEC: r.ok = secondary_allowed(d, p, path);
      FN_START_SEC: begin
        i = open_record(d, p, now);
        if (i >= 0 && secondary_allowed(d, p, path)) begin
          tbl[i].phase = PH_SEC;
          tbl[i].path = path;
          tbl[i].tried |= bit_of(path);
          tbl[i].secs = bump(tbl[i].secs);
          r.ok = 1'b1;
        end
      end
      FN_CARRIER: begin
        i = find_key(d, p);
        if (i >= 0 && !terminal(tbl[i].phase) &&
            !(tbl[i].phase == PH_SEC && tbl[i].path != path)) begin
          tbl[i].updated = now;
          tbl[i].path = PATH_NONE;
          if (acc) begin
            tbl[i].acc |= bit_of(path);
            tbl[i].phase = PH_ACC;
          end else begin
            tbl[i].phase = PH_RECOV;
          end
          r.ok = 1'b1;
        end
      end
      FN_DELIVERED: begin
        i = find_key(d, p);
        if (i >= 0 && tbl[i].phase != PH_CANC && tbl[i].phase != PH_EXP) begin
          tbl[i].phase = PH_DELIV;
          tbl[i].path = PATH_NONE;
          tbl[i].updated = now;
          r.ok = 1'b1;
        end
      end
      FN_CANCELLED: begin
        i = find_key(d, p);
        if (i >= 0 && tbl[i].phase != PH_DELIV && tbl[i].phase != PH_EXP) begin
          tbl[i].phase = PH_CANC;
          tbl[i].path = PATH_NONE;
          tbl[i].updated = now;
          r.ok = 1'b1;
        end
      end
      FN_EXPIRE: begin
        for (int k = 0; k < NSlots; k++)
          if (used[k] && !terminal(tbl[k].phase) && 32'(now - tbl[k].created) > ttl) begin
            tbl[k].phase = PH_EXP;
            tbl[k].path = PATH_NONE;
            tbl[k].updated = now;
          end
        r.ok = 1'b1;
      end
      FN_CLEAR: begin
        for (int k = 0; k < NSlots; k++) used[k] = 1'b0;
        r.ok = 1'b1;
      end
      default: r.ok = 1'b0;
    endcase
    i = find_key(d, p);
    if (i >= 0) begin
      r.found = 1'b1;
      r.phase = tbl[i].phase;
      r.path = tbl[i].path;
      r.tried = tbl[i].tried;
      r.acc = tbl[i].acc;
      r.fails = tbl[i].fails;
      r.secs = tbl[i].secs;
    end
    return r;
  endfunction

  // predict on accepted requests, compare on result strobes
  always @(posedge clk_i or negedge rst_ni) begin
    report_t want, got;
    if (!rst_ni) begin
      for (int k = 0; k < NSlots; k++) used[k] = 1'b0;
      ttl = TtlReset;
      fail_cnt = 0;
      report_q.delete();
    end else begin
      if (valid_o) begin
        got = {ok_o, found_o, phase_o, active_path_o, tried_mask_o, accepted_mask_o,
               fail_count_o, secondary_count_o};
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          fail_cnt++;
        end else begin
          want = report_q.pop_front();
          if (want.ok != got.ok || want.found != got.found || want.phase != got.phase ||
              want.path != got.path || want.tried != got.tried || want.acc != got.acc ||
              want.fails != got.fails || want.secs != got.secs) begin
            $display("%0t: mismatch expected ok%b fd%b ph%0d pa%0d tr%0h ac%0h f%0d s%0d",
                     $realtime, want.ok, want.found, want.phase, want.path, want.tried,
                     want.acc, want.fails, want.secs);
            $display("%0t:          actual   ok%b fd%b ph%0d pa%0d tr%0h ac%0h f%0d s%0d",
                     $realtime, got.ok, got.found, got.phase, got.path, got.tried,
                     got.acc, got.fails, got.secs);
            fail_cnt++;
          end
        end
      end
      if (cfg_we_i) ttl = cfg_wdata_i;
      if (start_i && !busy_o)
        report_q.push_back(track_event(func_i, destination_i, packet_id_i, carrier_path_i,
                                       carrier_accepted_i, now_ms_i));
    end
  end
endmodule

// ===== test/tb_packet_delivery_tracker_unit.sv =====
// testbench top for packet_delivery_tracker_unit: clock, reset, request stimulus, verdict
// depends on pdt_pkg, the tracker RTL and pdt_checker
module tb_packet_delivery_tracker_unit;
  import pdt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [3:0]  func_i = '0;
  logic [31:0] destination_i = '0;
  logic [31:0] packet_id_i = '0;
  logic [1:0]  carrier_path_i = '0;
  logic        carrier_accepted_i = 1'b0;
  logic [31:0] now_ms_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        valid_o, ok_o, found_o;
  logic [2:0]  phase_o, tried_mask_o, accepted_mask_o;
  logic [1:0]  active_path_o;
  logic [7:0]  fail_count_o, secondary_count_o;
  int          fail_cnt, pending_cnt;
  int          cycle_cnt = 0;
  logic [31:0] clock_ms = 32'd100;
  logic [31:0] dest_pool [8];
  logic [31:0] pkt_pool [8];

  localparam int CycleLimit = 400000;

  always #5 clk_i = ~clk_i;

  packet_delivery_tracker_unit uut (.*);
  pdt_checker chk (.*);

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_packet_delivery_tracker_unit: errors");
      $finish;
    end
  end

  // one request, held until accepted
  task automatic send_request(logic [3:0] fn, logic [31:0] d, logic [31:0] p,
                              logic [1:0] path, logic acc, logic [31:0] now);
    func_i <= fn;
    destination_i <= d;
    packet_id_i <= p;
    carrier_path_i <= path;
    carrier_accepted_i <= acc;
    now_ms_i <= now;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic pause(int n);
    start_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic set_ttl(logic [31:0] v);
    start_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (25) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random event, mostly on a small pool of keys so records live long
  task automatic random_event();
    logic [3:0] fn;
    logic [31:0] d, p;
    int k;
    k = $urandom_range(0, 7);
    d = dest_pool[k];
    p = pkt_pool[$urandom_range(0, 7)];
    if ($urandom_range(0, 19) == 0) d = $urandom_range(0, 1) ? 32'd0 : $urandom;
    if ($urandom_range(0, 19) == 0) p = $urandom_range(0, 1) ? 32'd0 : $urandom;
    case ($urandom_range(0, 99)) inside
      [0:14]:  fn = FN_BEGIN;
      [15:24]: fn = FN_PRIM_ACT;
      [25:34]: fn = FN_PRIM_FAIL;
      [35:41]: fn = FN_QUEUE_REC;
      [42:50]: fn = FN_QUERY_SEC;
      [51:64]: fn = FN_START_SEC;
      [65:78]: fn = FN_CARRIER;
      [79:84]: fn = FN_DELIVERED;
      [85:89]: fn = FN_CANCELLED;
      [90:95]: fn = FN_EXPIRE;
      [96:96]: fn = FN_CLEAR;
      default: fn = 4'($urandom_range(11, 15));
    endcase
    if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 4000);
    send_request(fn, d, p, 2'($urandom), 1'($urandom), clock_ms);
  endtask

  initial begin
    int n;
    for (int k = 0; k < 8; k++) begin
      dest_pool[k] = (k == 7) ? 32'hFFFF_FFFF : $urandom_range(1, 40);
      pkt_pool[k] = (k == 7) ? 32'hFFFF_FFFF : $urandom_range(1, 6);
    end
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: key extremes, every event, refusal cases
    send_request(FN_BEGIN, 32'd0, 32'd5, PATH_NONE, 1'b0, 32'd1);
    send_request(FN_PRIM_ACT, 32'd5, 32'd0, PATH_NONE, 1'b0, 32'd1);
    send_request(FN_START_SEC, 32'd0, 32'd0, PATH_SECOND, 1'b0, 32'd1);
    send_request(FN_QUERY_SEC, 32'd9, 32'd9, PATH_THIRD, 1'b0, 32'd2);
    send_request(FN_QUERY_SEC, 32'd9, 32'd9, PATH_PRIMARY, 1'b0, 32'd2);
    send_request(FN_BEGIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PATH_NONE, 1'b0, 32'hFFFF_FFFF);
    send_request(FN_PRIM_FAIL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PATH_NONE, 1'b0, 32'd3);
    send_request(FN_START_SEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PATH_PRIMARY, 1'b0, 32'd4);
    send_request(FN_START_SEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PATH_THIRD, 1'b0, 32'd5);
    send_request(FN_CARRIER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PATH_SECOND, 1'b1, 32'd6);
    send_request(FN_CARRIER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PATH_THIRD, 1'b1, 32'd7);
    send_request(FN_DELIVERED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PATH_NONE, 1'b0, 32'd8);
    send_request(FN_BEGIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PATH_NONE, 1'b0, 32'd9);
    send_request(FN_QUEUE_REC, 32'd7, 32'd7, PATH_NONE, 1'b0, 32'd10);
    send_request(FN_CARRIER, 32'd7, 32'd7, PATH_NONE, 1'b1, 32'd11);
    send_request(FN_CANCELLED, 32'd7, 32'd7, PATH_NONE, 1'b0, 32'd12);
    send_request(FN_DELIVERED, 32'd7, 32'd7, PATH_NONE, 1'b0, 32'd12);
    send_request(FN_BEGIN, 32'd3, 32'd3, PATH_NONE, 1'b0, 32'd0);
    send_request(FN_EXPIRE, 32'd3, 32'd3, PATH_NONE, 1'b0, 32'd40000);
    send_request(4'd15, 32'd3, 32'd3, PATH_NONE, 1'b0, 32'd40001);
    send_request(FN_CLEAR, 32'd3, 32'd3, PATH_NONE, 1'b0, 32'd40002);

    // fill past the table size so allocation must evict
    for (int k = 1; k <= 20; k++)
      send_request(FN_BEGIN, 32'(k), 32'd1, PATH_NONE, 1'b0, 32'(1000 - 7 * k));
    for (int k = 21; k <= 24; k++)
      send_request(FN_PRIM_FAIL, 32'(k), 32'd2, PATH_NONE, 1'b0, 32'(2000 + k));
    send_request(FN_CLEAR, 32'd1, 32'd1, PATH_NONE, 1'b0, 32'd0);

    // random phases under several lifetimes, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_ttl(32'd0);
        1: set_ttl(32'hFFFF_FFFF);
        2: set_ttl(32'd5000);
        default: set_ttl($urandom);
      endcase
      n = 0;
      while (n < 280) begin
        repeat ($urandom_range(1, 30)) begin
          random_event();
          n++;
        end
        if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 60));
      end
    end

    start_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (fail_cnt == 0) $display("tb_packet_delivery_tracker_unit: clean");
    else $display("tb_packet_delivery_tracker_unit: errors");
    $finish;
  end
endmodule
